FILE: rtl/pfde_pkg.sv
package pfde_pkg;

  // Store geometry
  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  // Wide enough for x + page * width: 255 + 31 * 255
  localparam int CALC_W      = 14;
  localparam int PROD_W      = 13;

  // Configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [7:0] PANEL_WIDTH_RST  = 8'd128;
  localparam logic [6:0] PANEL_HEIGHT_RST = 7'd64;

  // Glyph font
  localparam logic [7:0] GLYPH_FIRST = 8'd48;
  localparam logic [7:0] GLYPH_LAST  = 8'd58;
  localparam int         GLYPH_COLS  = 5;
  localparam int         GLYPH_NUM   = 11;

  localparam logic [7:0] FONT_ROM [0:GLYPH_NUM-1][0:GLYPH_COLS-1] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
    '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
    '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}
  };

  typedef enum logic [1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_GLYPH = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic {
    REG_PANEL_WIDTH  = 1'b0,
    REG_PANEL_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_STEP,
    ST_WRITE,
    ST_CLEAR,
    ST_READ,
    ST_CAPTURE,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  glyph_code;
    logic        ink;
    logic [9:0]  read_index;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        drew;
  } rsp_item_t;

  typedef struct packed {
    logic [7:0]  panel_width;
    logic [6:0]  panel_height;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic advance;
    logic rd_step;
    logic wr_step;
    logic rd_index;
    logic cap_byte;
    logic clr_start;
    logic clr_wr;
    logic set_drew;
    logic load_out;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic step_hit;
    logic exhausted;
    logic clr_last;
  } sts_t;

  function automatic logic [7:0] font_col(input logic [3:0] glyph, input logic [2:0] col);
    logic [7:0] bits;
    bits = 8'h00;
    if (glyph < 4'(GLYPH_NUM) && col < 3'(GLYPH_COLS)) begin
      bits = FONT_ROM[glyph][col];
    end
    return bits;
  endfunction

endpackage

FILE: rtl/pfde_if.sv
interface pfde_cmd_if import pfde_pkg::*;;
  logic      valid;
  logic      ready;
  cmd_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pfde_rsp_if import pfde_pkg::*;;
  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/pfde_regs.sv
module pfde_regs import pfde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t   reg_idx;
  logic       wr_en;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_width  <= PANEL_WIDTH_RST;
      cfg.panel_height <= PANEL_HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PANEL_WIDTH:  cfg.panel_width  <= pwdata[7:0];
        REG_PANEL_HEIGHT: cfg.panel_height <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PANEL_WIDTH:  prdata = {24'd0, cfg.panel_width};
      REG_PANEL_HEIGHT: prdata = {25'd0, cfg.panel_height};
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/pfde_ctrl.sv
module pfde_ctrl import pfde_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  input  func_t cmd_func,
  output logic  cmd_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  sts_t  sts,
  output ctl_t  ctl
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;

    case (state)
      ST_INIT: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.accept = 1'b1;
          case (cmd_func)
            FUNC_PIXEL, FUNC_GLYPH: state_next = ST_STEP;
            FUNC_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
            default: state_next = ST_READ;
          endcase
        end
      end

      // Evaluate one column/page step; in ST_WRITE also retire the previous one
      ST_STEP, ST_WRITE: begin
        ctl.wr_step = (state == ST_WRITE);
        if (sts.exhausted) begin
          state_next = ST_DONE;
        end else begin
          ctl.advance = 1'b1;
          ctl.rd_step = sts.step_hit;
          state_next  = sts.step_hit ? ST_WRITE : ST_STEP;
        end
      end

      ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          ctl.set_drew = 1'b1;
          state_next   = ST_DONE;
        end
      end

      ST_READ: begin
        ctl.rd_index = 1'b1;
        state_next   = ST_CAPTURE;
      end

      ST_CAPTURE: begin
        ctl.cap_byte = 1'b1;
        state_next   = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || rsp_ready) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: rtl/pfde_datapath.sv
module pfde_datapath import pfde_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_item_t item,
  input  cfg_t      cfg,
  input  ctl_t      ctl,
  output sts_t      sts,
  output rsp_item_t result
);

  logic [7:0]        mem [STORE_BYTES];

  cmd_item_t         op;
  logic [2:0]        col_idx;
  logic              page_sel;
  logic              exhausted;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;
  logic [7:0]        rd_data;
  logic              work_drew;
  logic [7:0]        work_byte;
  logic [ADDR_W-1:0] clr_cnt;

  logic              is_glyph;
  logic              glyph_ok;
  logic [3:0]        glyph_idx;
  logic [7:0]        col_bits;
  logic [7:0]        step_x;
  logic [15:0]       shifted;
  logic [4:0]        page;
  logic [7:0]        page_bits;
  logic [7:0]        row_ok;
  logic [7:0]        step_mask;
  logic [PROD_W-1:0] page_base;
  logic [CALC_W-1:0] step_addr;
  logic [CALC_W-1:0] rd_idx_ext;
  logic              rd_in_range;
  logic              last_col;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic [7:0]        merged;

  // Step geometry: glyph column col_idx lands in the page of pos_y (lower half)
  // or the following page (upper half), wrapping over 32 pages
  assign is_glyph  = (op.func == FUNC_GLYPH);
  assign glyph_ok  = (op.glyph_code >= GLYPH_FIRST) && (op.glyph_code <= GLYPH_LAST);
  assign glyph_idx = 4'(op.glyph_code - GLYPH_FIRST);
  assign col_bits  = is_glyph ? font_col(glyph_idx, col_idx) : 8'h01;
  assign step_x    = op.pos_x + {5'd0, col_idx};
  assign shifted   = {8'd0, col_bits} << op.pos_y[2:0];
  assign page      = op.pos_y[7:3] + {4'd0, page_sel};
  assign page_bits = page_sel ? shifted[15:8] : shifted[7:0];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      row_ok[k] = {page, 3'(k)} < {1'b0, cfg.panel_height};
    end
  end

  assign step_mask = page_bits & row_ok;
  assign page_base = {8'd0, page} * {5'd0, cfg.panel_width};
  assign step_addr = {1'b0, page_base} + {6'd0, step_x};

  assign sts.step_hit  = (!is_glyph || glyph_ok) && (step_x < cfg.panel_width) &&
                         (step_addr < CALC_W'(STORE_BYTES)) && (step_mask != 8'h00);
  assign sts.exhausted = exhausted;
  assign sts.clr_last  = (clr_cnt == ADDR_W'(STORE_BYTES - 1));

  assign last_col    = (col_idx == (is_glyph ? 3'(GLYPH_COLS - 1) : 3'd0));
  assign rd_idx_ext  = {4'd0, op.read_index};
  assign rd_in_range = (rd_idx_ext < CALC_W'(STORE_BYTES));
  assign rd_addr     = ctl.rd_step ? step_addr[ADDR_W-1:0] : rd_idx_ext[ADDR_W-1:0];

  assign merged = op.ink ? (rd_data | wr_mask) : (rd_data & ~wr_mask);
  assign mem_we = ctl.wr_step || ctl.clr_wr;
  assign mem_wa = ctl.wr_step ? wr_addr : clr_cnt;
  assign mem_wd = ctl.wr_step ? merged : 8'h00;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctl.rd_step || ctl.rd_index) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr_start) begin
      clr_cnt <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op        <= item;
      col_idx   <= '0;
      page_sel  <= 1'b0;
      exhausted <= 1'b0;
      work_drew <= 1'b0;
      work_byte <= '0;
    end else begin
      if (ctl.advance) begin
        page_sel <= !page_sel;
        if (page_sel) begin
          if (last_col) begin
            exhausted <= 1'b1;
          end else begin
            col_idx <= col_idx + 3'd1;
          end
        end
      end
      if (ctl.wr_step || ctl.set_drew) begin
        work_drew <= 1'b1;
      end
      if (ctl.cap_byte) begin
        work_byte <= rd_in_range ? rd_data : 8'h00;
      end
    end
    if (ctl.rd_step) begin
      wr_addr <= step_addr[ADDR_W-1:0];
      wr_mask <= step_mask;
    end
    if (ctl.load_out) begin
      result.read_byte <= work_byte;
      result.drew      <= work_drew;
    end
  end

endmodule

FILE: rtl/page_framebuffer_draw_engine.sv
// Monochrome framebuffer held as vertical eight-pixel page bytes in a single-port-write,
// single-port-read store of STORE_BYTES bytes (byte x + page * panel_width, bit y mod 8).
// Each item on cmd draws a pixel, draws a 5x7 digit or colon glyph, clears the store or
// reads one byte, and gives exactly one result on rsp; one item is worked at a time, and
// a finished result waits in the rsp register while the next item is taken. A glyph is
// walked as ten column/page steps evaluated one per cycle, with the read-modify-write of
// one step overlapping the store read of the next; the walk is then closed and the result
// loaded. A clear writes one store byte per cycle.
// After reset the store is cleared in a pass over every byte, during which cmd.ready
// stays low; panel_width and panel_height may be written over APB at any time the engine
// is idle, including during that pass.
module page_framebuffer_draw_engine import pfde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  pfde_cmd_if.sink           cmd,
  pfde_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  ctl_t      ctl;
  sts_t      sts;
  rsp_item_t result;

  // Panel geometry registers
  pfde_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: takes items, walks pixel and glyph steps, runs clear sweeps and reads, holds the result valid
  pfde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_func  (cmd.item.func),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Address and mask generation, pixel store and result register
  pfde_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd.item),
    .cfg    (cfg),
    .ctl    (ctl),
    .sts    (sts),
    .result (result)
  );

  assign rsp.item = result;

`ifndef ASSERT_OFF
  // Only one item is in flight: an accepted item drops ready on the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("item accepted while another is in progress");

  // Never overwrite a result that is still waiting to be taken
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!rsp.valid || rsp.ready))
    else $error("result register loaded while holding an untaken result");

  // A step write always follows the store read of that step
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_step |-> $past(ctl.rd_step))
    else $error("step write without preceding store read");

  // Clear sweep and step writes never share the store write port
  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(ctl.wr_step && ctl.clr_wr))
    else $error("clear sweep and step write in the same cycle");
`endif

endmodule

FILE: tb/page_framebuffer_draw_engine_test.sv
`timescale 1ns / 100ps

module page_framebuffer_draw_engine_test;
  import pfde_pkg::*;

  // Cycles with no handshake anywhere before the run is declared hung. The slowest
  // quiet stretch is a store clear followed by the longest receiver hold-off and the
  // longest sender gap, so this leaves ample margin.
  localparam int WATCHDOG_CYCLES = 8000;
  // Length of the deliberate receiver hold-off that backs the engine up.
  localparam int LONG_HOLD       = 300;
  // Quiet cycles after the last result, to catch a stray extra result.
  localparam int TAIL_CYCLES     = 40;
  localparam int N_DIRECTED      = 25;
  localparam int N_PHASES        = 10;
  localparam bit FIXED           = 1'b1;
  localparam bit PREDICTED       = 1'b0;

  typedef struct {
    func_t      op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] code;
    bit         ink;
    logic [9:0] ridx;
    bit         known;
    logic [7:0] want_byte;
    bit         want_drew;
  } directed_row_t;

  typedef struct {
    int unsigned width;
    int unsigned height;
    int unsigned items;
  } phase_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pfde_cmd_if cmd ();
  pfde_rsp_if rsp ();

  page_framebuffer_draw_engine i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow framebuffer: our own copy of the page store and panel geometry,
  // updated in acceptance order so it always matches what the engine should hold.
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_store [STORE_BYTES];
  int unsigned shadow_width  = PANEL_WIDTH_RST;
  int unsigned shadow_height = PANEL_HEIGHT_RST;

  // Outcomes still owed by the engine, oldest first.
  rsp_item_t outcome_q [$];
  int        mismatches = 0;

  // Idling controls shared between the stimulus and the receiver.
  bit cmd_idle_on = 1'b1;
  bit rsp_idle_on = 1'b1;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int idle_cycles = 0;

  // Set or clear one pixel; drop it when it falls outside the panel or the store.
  function automatic bit plot_pixel(int unsigned x, int unsigned y, bit ink);
    int unsigned addr;
    if (x >= shadow_width || y >= shadow_height) return 1'b0;
    addr = x + (y >> 3) * shadow_width;
    if (addr >= STORE_BYTES) return 1'b0;
    shadow_store[addr][y & 7] = ink;
    return 1'b1;
  endfunction

  // Apply one command to the shadow framebuffer and return what the engine must answer.
  function automatic rsp_item_t draw_outcome(cmd_item_t c);
    rsp_item_t  r;
    logic [7:0] col;
    logic [7:0] gx;
    logic [7:0] gy;
    r = '0;
    case (c.func)
      FUNC_PIXEL: r.drew = plot_pixel(c.pos_x, c.pos_y, c.ink);
      FUNC_GLYPH: begin
        // Unknown codes draw nothing; glyph coordinates wrap at 8 bits.
        if (c.glyph_code >= GLYPH_FIRST && c.glyph_code <= GLYPH_LAST) begin
          for (int i = 0; i < GLYPH_COLS; i++) begin
            col = FONT_ROM[c.glyph_code - GLYPH_FIRST][i];
            for (int j = 0; j < 7; j++) begin
              if (col[j]) begin
                gx = c.pos_x + 8'(i);
                gy = c.pos_y + 8'(j);
                if (plot_pixel(gx, gy, c.ink)) r.drew = 1'b1;
              end
            end
          end
        end
      end
      FUNC_CLEAR: begin
        foreach (shadow_store[a]) shadow_store[a] = '0;
        r.drew = 1'b1;
      end
      default: begin
        if (c.read_index < STORE_BYTES) r.read_byte = shadow_store[c.read_index];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Gap length: mostly none, often short, now and then long.
  function automatic int pick_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Coordinate: mostly on the panel, some near its edge, some anywhere in 8 bits.
  function automatic logic [7:0] pick_coord(int unsigned lim);
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(9, 0);
    if (lim == 0 || r >= 8) return 8'($urandom_range(255, 0));
    if (r == 7) begin
      lo = (lim > 6) ? lim - 6 : 0;
      hi = (lim + 2 > 255) ? 255 : lim + 2;
      return 8'($urandom_range(hi, lo));
    end
    return 8'($urandom_range(((lim > 256) ? 256 : lim) - 1, 0));
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t   c;
    int unsigned r;
    int unsigned px;
    int unsigned py;
    r = $urandom_range(99, 0);
    // Keep clears rare: each one costs a full pass over the store.
    if (r < 2) c.func = FUNC_CLEAR;
    else if (r < 36) c.func = FUNC_PIXEL;
    else if (r < 68) c.func = FUNC_GLYPH;
    else c.func = FUNC_READ;
    c.pos_x = pick_coord(shadow_width);
    c.pos_y = pick_coord(shadow_height);
    if ($urandom_range(99, 0) < 85) c.glyph_code = 8'($urandom_range(GLYPH_LAST, GLYPH_FIRST));
    else c.glyph_code = 8'($urandom());
    c.ink = ($urandom_range(99, 0) < 65);
    // Half the reads aim at bytes that drawing is likely to have touched.
    if ($urandom_range(1, 0)) begin
      c.read_index = 10'($urandom());
    end else begin
      px = pick_coord(shadow_width);
      py = pick_coord(shadow_height);
      c.read_index = 10'(px + (py >> 3) * shadow_width);
    end
    return c;
  endfunction

  // Offer one item, hold it until accepted, then record what it must produce.
  // Rows with a hand-written answer still go through the shadow store to keep it current.
  task automatic offer(input cmd_item_t c, input bit known, input rsp_item_t fixed_rsp);
    int        gap;
    rsp_item_t want;
    gap = pick_gap(cmd_idle_on);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.item  <= c;
    do @(posedge clk); while (!cmd.ready);
    want = draw_outcome(c);
    outcome_q.push_back(known ? fixed_rsp : want);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] mask;
    mask = (idx == REG_PANEL_WIDTH) ? 32'h0000_00FF : 32'h0000_007F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask))
      report_mismatch("register read-back", prdata & mask, value & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_PANEL_WIDTH) shadow_width = value & mask;
    else shadow_height = value & mask;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each result against the oldest owed outcome, then decide
  // whether to take the next one. A hold request stalls it for the long hold-off (LONG_HOLD).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_item_t want;
    int        g;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing owed, read_byte", rsp.item.read_byte, 0);
        end else begin
          want = outcome_q.pop_front();
          if (rsp.item.read_byte !== want.read_byte)
            report_mismatch("read_byte", rsp.item.read_byte, want.read_byte);
          if (rsp.item.drew !== want.drew)
            report_mismatch("drew", rsp.item.drew, want.drew);
        end
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        g = pick_gap(rsp_idle_on);
        if (g > 0) begin
          hold_left = g - 1;
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: any handshake on either channel or the register port resets it.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("page_framebuffer_draw_engine_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed items, run at the reset geometry (128 x 64) on an empty store.
  // Hand-written answers where obvious; the rest take the shadow store's answer.
  // ---------------------------------------------------------------------------
  directed_row_t directed_rows [N_DIRECTED] = '{
    // empty store reads back zero at both ends
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd0,    FIXED, 8'h00, 1'b0},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd1023, FIXED, 8'h00, 1'b0},
    // corner pixels, top-left and bottom-right of the panel
    '{FUNC_PIXEL, 8'd0,   8'd0,   8'd0,  1'b1, 10'd0,    FIXED, 8'h00, 1'b1},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd0,    FIXED, 8'h01, 1'b0},
    '{FUNC_PIXEL, 8'd127, 8'd63,  8'd0,  1'b1, 10'd0,    FIXED, 8'h00, 1'b1},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd1023, FIXED, 8'h80, 1'b0},
    // just off the panel, and the far corner of the coordinate space
    '{FUNC_PIXEL, 8'd128, 8'd0,   8'd0,  1'b1, 10'd0,    FIXED, 8'h00, 1'b0},
    '{FUNC_PIXEL, 8'd0,   8'd64,  8'd0,  1'b1, 10'd0,    FIXED, 8'h00, 1'b0},
    '{FUNC_PIXEL, 8'd255, 8'd255, 8'd0,  1'b1, 10'd0,    FIXED, 8'h00, 1'b0},
    // clear ink on a set pixel
    '{FUNC_PIXEL, 8'd0,   8'd0,   8'd0,  1'b0, 10'd0,    FIXED, 8'h00, 1'b1},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd0,    FIXED, 8'h00, 1'b0},
    // glyph on the second page, then read its first column
    '{FUNC_GLYPH, 8'd10,  8'd8,   GLYPH_FIRST, 1'b1, 10'd0,   PREDICTED, 8'h00, 1'b0},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd138,  PREDICTED, 8'h00, 1'b0},
    // glyph wrapping round both axes, partly landing in the top-left corner
    '{FUNC_GLYPH, 8'd254, 8'd254, 8'(GLYPH_FIRST + 8), 1'b1, 10'd0, PREDICTED, 8'h00, 1'b0},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd0,    PREDICTED, 8'h00, 1'b0},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd1,    PREDICTED, 8'h00, 1'b0},
    // codes just outside the font, and the top code
    '{FUNC_GLYPH, 8'd20,  8'd20,  8'(GLYPH_FIRST - 1), 1'b1, 10'd0, FIXED, 8'h00, 1'b0},
    '{FUNC_GLYPH, 8'd20,  8'd20,  8'(GLYPH_LAST + 1),  1'b1, 10'd0, FIXED, 8'h00, 1'b0},
    '{FUNC_GLYPH, 8'd20,  8'd20,  8'hFF, 1'b1, 10'd0,    FIXED, 8'h00, 1'b0},
    // colon clipped at the bottom-right corner
    '{FUNC_GLYPH, 8'd124, 8'd60,  GLYPH_LAST, 1'b1, 10'd0,    PREDICTED, 8'h00, 1'b0},
    // erase the first glyph again
    '{FUNC_GLYPH, 8'd10,  8'd8,   GLYPH_FIRST, 1'b0, 10'd0,   PREDICTED, 8'h00, 1'b0},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd138,  PREDICTED, 8'h00, 1'b0},
    // whole-store clear, then reads of a cleared store
    '{FUNC_CLEAR, 8'd0,   8'd0,   8'd0,  1'b0, 10'd0,    FIXED, 8'h00, 1'b1},
    '{FUNC_READ,  8'd0,   8'd0,   8'd0,  1'b0, 10'd1023, FIXED, 8'h00, 1'b0},
    '{FUNC_READ,  8'd255, 8'd255, 8'hFF, 1'b1, 10'd682,  FIXED, 8'h00, 1'b0}
  };

  // Random phases: one panel geometry each, including the extremes, a zero-sized
  // panel on each axis, and an oversized one whose lower pages fall beyond the store.
  phase_t plan [N_PHASES] = '{
    '{128, 64, 200},
    '{1,   8,  80},
    '{128, 8,  120},
    '{1,   64, 80},
    '{37,  23, 130},
    '{0,   64, 30},
    '{64,  0,  30},
    '{200, 127, 140},
    '{96,  40, 110},
    '{128, 64, 110}
  };

  initial begin
    cmd_item_t c;
    rsp_item_t fixed_rsp;
    cmd.valid = 1'b0;
    cmd.item  = '0;
    foreach (shadow_store[a]) shadow_store[a] = '0;

    // Hold reset, then release; the engine's clearing pass holds off the first item.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < N_DIRECTED; n++) begin
      c.func       = directed_rows[n].op;
      c.pos_x      = directed_rows[n].x;
      c.pos_y      = directed_rows[n].y;
      c.glyph_code = directed_rows[n].code;
      c.ink        = directed_rows[n].ink;
      c.read_index = directed_rows[n].ridx;
      fixed_rsp.read_byte = directed_rows[n].want_byte;
      fixed_rsp.drew      = directed_rows[n].want_drew;
      offer(c, directed_rows[n].known, fixed_rsp);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // Reconfigure only once the engine has nothing in hand.
      if (p > 0) begin
        drain();
        write_reg(REG_PANEL_WIDTH, plan[p].width);
        write_reg(REG_PANEL_HEIGHT, plan[p].height);
      end
      // Every third phase runs flat out on both sides.
      cmd_idle_on = (p % 3 != 2);
      rsp_idle_on = (p % 3 != 2);
      for (int k = 0; k < plan[p].items; k++) begin
        // Stall the receiver for a long stretch while items keep coming...
        if (p == 0 && k == 40) hold_req = 1'b1;
        // ...and later let the engine run completely dry before carrying on.
        if (p == 0 && k == 120) drain();
        offer(random_command(), PREDICTED, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("page_framebuffer_draw_engine_test passed");
    end else begin
      $display("page_framebuffer_draw_engine_test failed");
    end
    $finish;
  end

endmodule

FILE: page_framebuffer_draw_engine.f
rtl/pfde_pkg.sv
rtl/pfde_if.sv
rtl/pfde_regs.sv
rtl/pfde_ctrl.sv
rtl/pfde_datapath.sv
rtl/page_framebuffer_draw_engine.sv
tb/page_framebuffer_draw_engine_test.sv
